[sv/cldr_pkg.sv]
// ----------------------------------------------------------------------------
// cldr_pkg
// Shared constants and types for the character LCD dirty-cell refresh core.
// ----------------------------------------------------------------------------
package cldr_pkg;

    // Default geometry: two rows of eight cells
    localparam int CELLS_DEF     = 16;
    localparam int ROW_CELLS_DEF = 8;

    // Set-DDRAM-address command bases for the two rows
    localparam logic [7:0] CMD_ROW0 = 8'h80;
    localparam logic [7:0] CMD_ROW1 = 8'hC0;

    // Reset contents of the shadow buffers
    localparam logic [7:0] WANTED_RESET = 8'h00;
    localparam logic [7:0] SENT_RESET   = 8'hFF;

    // Request kinds (s_tuser)
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // Register select on the display bus (m_tuser)
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Output queue depth: covers one request in flight plus one waiting
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
    } out_item_t;

endpackage

[sv/cldr_ram.sv]
// ----------------------------------------------------------------------------
// cldr_ram
// Generic RAM: one write port, two read ports, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cldr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[sv/char_lcd_dirty_refresh_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_dirty_refresh_core
// Round-robin refresher for a two-row character display on a 4-bit bus.
// Store requests fill the wanted-text buffer; tick requests step a sequencer
// that sends only cells whose wanted code differs from the code last sent.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------
//  s_      | in  | s_tvalid/tready  | tdata: position, char_code; tuser: func
//  m_      | out | m_tvalid/tready  | tdata: nibble; tuser: reg_select
//  cfg_    | in  | cfg_wr_en        | cfg_wr_data: display_on
//
//  One request per cycle while s_tready is high. A request reads both text
//  RAMs in the cycle it is accepted and is processed in the next, as the RAM
//  read data is registered; its strobe, if any, then goes into the m_ queue.
//  Reset takes effect at once: per-entry valid bits stand for the reset
//  contents, so there is no clearing pass. s_tready drops only when the
//  three-entry output queue could overflow under an m_ stall.
// ----------------------------------------------------------------------------
module char_lcd_dirty_refresh_core #(
    parameter int CELLS     = cldr_pkg::CELLS_DEF,
    parameter int ROW_CELLS = cldr_pkg::ROW_CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // display_on
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [3:0] position, [11:4] char_code
    input  logic        s_tuser,       // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [3:0] nibble
    output logic        m_tuser        // [0] reg_select
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    // configuration
    logic display_on_reg;

    // accepted request waiting for its RAM data
    logic          p_valid_reg;
    logic          p_func_reg;
    logic [3:0]    p_pos_reg;
    logic [7:0]    p_char_reg;
    logic [AW-1:0] rd_base_reg;

    // sequencer
    logic [AW-1:0] cell_idx_reg,   cell_idx_next;
    logic          move_pend_reg,  move_pend_next;
    logic          cmd_act_reg,    cmd_act_next;
    logic [7:0]    cmd_byte_reg,   cmd_byte_next;
    logic          low_half_reg,   low_half_next;
    logic [3:0]    latch_reg,      latch_next;

    // valid bits stand in for the reset contents
    logic [CELLS-1:0] wv_reg, sv_reg;
    logic wv_a_reg, wv_b_reg, sv_a_reg, sv_b_reg;

    // forwarding of the previous write
    logic          fw_w_en_reg, fw_s_en_reg;
    logic [AW-1:0] fw_w_addr_reg, fw_s_addr_reg;
    logic [7:0]    fw_w_data_reg, fw_s_data_reg;

    // RAM ports
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [7:0]    w_rd_a, w_rd_b, s_rd_a, s_rd_b;
    logic          w_wr_en, s_wr_en;
    logic [AW-1:0] w_wr_addr, s_wr_addr;
    logic [7:0]    w_wr_data, s_wr_data;

    // output queue
    cldr_pkg::out_item_t q_mem_reg [cldr_pkg::OUT_DEPTH];
    logic [1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0] q_cnt_reg;
    logic       push, pop;
    cldr_pkg::out_item_t res;

    // processing-stage values
    logic          accept;
    logic          sel_b;
    logic [7:0]    ram_w, ram_s, cur_w, cur_s;
    logic          vld_w, vld_s;
    logic [AW-1:0] idx_inc;
    logic [7:0]    cmd_for_cur;
    logic [7:0]    cmd_use;
    logic          cmd_use_act;
    logic [3:0]    half;
    logic          proc_tick;

    assign accept    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign s_tready  = ({1'b0, q_cnt_reg} + {2'b00, p_valid_reg}) <= 3'(cldr_pkg::OUT_DEPTH - 1);
    assign proc_tick = p_valid_reg && (p_func_reg == cldr_pkg::FUNC_TICK);

    // read the current cell and its successor; the request in flight moves
    // the index by at most one before this read is used
    assign rd_addr_a = cell_idx_reg;
    assign rd_addr_b = (cell_idx_reg == AW'(CELLS - 1)) ? '0 : cell_idx_reg + AW'(1);
    assign idx_inc   = rd_addr_b;

    cldr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_wanted_ram (
        .aclk      (aclk),
        .wr_en     (w_wr_en),
        .wr_addr   (w_wr_addr),
        .wr_data   (w_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (w_rd_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (w_rd_b)
    );

    cldr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_sent_ram (
        .aclk      (aclk),
        .wr_en     (s_wr_en),
        .wr_addr   (s_wr_addr),
        .wr_data   (s_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (s_rd_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (s_rd_b)
    );

    // pick the port that matches where the index ended up
    assign sel_b = (cell_idx_reg != rd_base_reg);
    assign ram_w = sel_b ? w_rd_b : w_rd_a;
    assign ram_s = sel_b ? s_rd_b : s_rd_a;
    assign vld_w = sel_b ? wv_b_reg : wv_a_reg;
    assign vld_s = sel_b ? sv_b_reg : sv_a_reg;

    always_comb begin
        if (fw_w_en_reg && fw_w_addr_reg == cell_idx_reg) begin
            cur_w = fw_w_data_reg;
        end else if (vld_w) begin
            cur_w = ram_w;
        end else begin
            cur_w = cldr_pkg::WANTED_RESET;
        end
        if (fw_s_en_reg && fw_s_addr_reg == cell_idx_reg) begin
            cur_s = fw_s_data_reg;
        end else if (vld_s) begin
            cur_s = ram_s;
        end else begin
            cur_s = cldr_pkg::SENT_RESET;
        end
    end

    assign cmd_for_cur = (32'(cell_idx_reg) < 32'(ROW_CELLS)) ?
        8'(32'(cldr_pkg::CMD_ROW0) + 32'(cell_idx_reg)) :
        8'(32'(cldr_pkg::CMD_ROW1) + 32'(cell_idx_reg) - 32'(ROW_CELLS));

    assign cmd_use     = move_pend_reg ? cmd_for_cur : cmd_byte_reg;
    assign cmd_use_act = move_pend_reg || cmd_act_reg;

    always_comb begin
        cell_idx_next  = cell_idx_reg;
        move_pend_next = move_pend_reg;
        cmd_act_next   = cmd_act_reg;
        cmd_byte_next  = cmd_byte_reg;
        low_half_next  = low_half_reg;
        latch_next     = latch_reg;
        half           = latch_reg;
        push           = 1'b0;
        res.reg_select = cldr_pkg::RS_DATA;
        w_wr_en        = 1'b0;
        w_wr_addr      = AW'(p_pos_reg);
        w_wr_data      = p_char_reg;
        s_wr_en        = 1'b0;
        s_wr_addr      = cell_idx_reg;
        s_wr_data      = cur_w;
        if (p_valid_reg) begin
            if (p_func_reg == cldr_pkg::FUNC_STORE) begin
                // drop stores beyond the buffer
                w_wr_en = (32'(p_pos_reg) < 32'(CELLS));
            end else if (!low_half_reg) begin
                if (!cmd_act_reg && cur_w == cur_s) begin
                    move_pend_next = 1'b1;
                    cell_idx_next  = idx_inc;
                end else begin
                    cmd_byte_next  = cmd_use;
                    cmd_act_next   = cmd_use_act;
                    move_pend_next = 1'b0;
                    half           = cmd_use_act ? cmd_use[7:4] : cur_w[7:4];
                    res.reg_select = cmd_use_act ? cldr_pkg::RS_CMD : cldr_pkg::RS_DATA;
                    low_half_next  = 1'b1;
                    push           = 1'b1;
                end
            end else begin
                if (cmd_act_reg) begin
                    half           = cmd_byte_reg[3:0];
                    res.reg_select = cldr_pkg::RS_CMD;
                    cmd_act_next   = 1'b0;
                end else begin
                    half           = cur_w[3:0];
                    res.reg_select = cldr_pkg::RS_DATA;
                    s_wr_en        = 1'b1;
                    cell_idx_next  = idx_inc;
                end
                low_half_next = 1'b0;
                push          = 1'b1;
            end
        end
        if (push && display_on_reg) begin
            latch_next = half;
        end
        res.nibble = latch_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_on_reg <= 1'b1;
            p_valid_reg    <= 1'b0;
            cell_idx_reg   <= '0;
            move_pend_reg  <= 1'b0;
            cmd_act_reg    <= 1'b0;
            cmd_byte_reg   <= cldr_pkg::CMD_ROW0;
            low_half_reg   <= 1'b0;
            latch_reg      <= '0;
            wv_reg         <= '0;
            sv_reg         <= '0;
            fw_w_en_reg    <= 1'b0;
            fw_s_en_reg    <= 1'b0;
            q_wr_ptr_reg   <= '0;
            q_rd_ptr_reg   <= '0;
            q_cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                display_on_reg <= cfg_wr_data;
            end
            p_valid_reg   <= accept;
            cell_idx_reg  <= cell_idx_next;
            move_pend_reg <= move_pend_next;
            cmd_act_reg   <= cmd_act_next;
            cmd_byte_reg  <= cmd_byte_next;
            low_half_reg  <= low_half_next;
            latch_reg     <= latch_next;
            if (w_wr_en) begin
                wv_reg[w_wr_addr] <= 1'b1;
            end
            if (s_wr_en) begin
                sv_reg[s_wr_addr] <= 1'b1;
            end
            fw_w_en_reg <= w_wr_en;
            fw_s_en_reg <= s_wr_en;
            if (push) begin
                q_wr_ptr_reg <= (q_wr_ptr_reg == 2'(cldr_pkg::OUT_DEPTH - 1)) ?
                                2'd0 : q_wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                q_rd_ptr_reg <= (q_rd_ptr_reg == 2'(cldr_pkg::OUT_DEPTH - 1)) ?
                                2'd0 : q_rd_ptr_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_func_reg <= s_tuser;
            p_pos_reg  <= s_tdata[3:0];
            p_char_reg <= s_tdata[11:4];
        end
        rd_base_reg   <= cell_idx_reg;
        wv_a_reg      <= wv_reg[rd_addr_a];
        wv_b_reg      <= wv_reg[rd_addr_b];
        sv_a_reg      <= sv_reg[rd_addr_a];
        sv_b_reg      <= sv_reg[rd_addr_b];
        fw_w_addr_reg <= w_wr_addr;
        fw_w_data_reg <= w_wr_data;
        fw_s_addr_reg <= s_wr_addr;
        fw_s_data_reg <= s_wr_data;
        if (push) begin
            q_mem_reg[q_wr_ptr_reg] <= res;
        end
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = {4'b0000, q_mem_reg[q_rd_ptr_reg].nibble};
    assign m_tuser  = q_mem_reg[q_rd_ptr_reg].reg_select;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && q_cnt_reg == 2'(cldr_pkg::OUT_DEPTH)))
        else $error("output queue overflow");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cell_idx_reg) < 32'(CELLS))
        else $error("cell index out of range");

    a_cmd_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_tick && cmd_act_reg && low_half_reg) |=> !cmd_act_reg)
        else $error("address command not closed after its low nibble");

    a_data_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_tick && !cmd_act_reg && low_half_reg) |=> cell_idx_reg != $past(cell_idx_reg))
        else $error("index did not advance after a low data nibble");

    a_store_no_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && p_func_reg == cldr_pkg::FUNC_STORE) |-> !push && !s_wr_en)
        else $error("store request produced a strobe");

endmodule
